>>> rtl/per_user_sliding_window_rate_limiter_macros.svh
// Assertion macros for the per-user sliding-window rate limiter.
// Included by the top level; no dependencies. Bodies vanish when SYNTH is defined.
`ifndef PER_USER_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_USER_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define PUSWRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rate limiter assertion failed");
// Next-cycle implication, checked outside reset
`define PUSWRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rate limiter assertion failed");
`else
`define PUSWRL_ASSERT_NOW(lbl, ante, cons)
`define PUSWRL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/puswrl_pkg.sv
// Shared constants, state encoding and controller/datapath interface structs
// for the per-user sliding-window rate limiter. No dependencies.
package puswrl_pkg;

  localparam int USER_W     = 6;
  localparam int LIMIT_W    = 4;
  localparam int WINDOW_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int QUOT_SHIFT = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 2'd2;

  // Configuration reset values
  localparam logic [LIMIT_W-1:0]  MESSAGE_LIMIT_RST = 4'd5;
  localparam logic [LIMIT_W-1:0]  COMMAND_LIMIT_RST = 4'd5;
  localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST  = 20'd10000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUOT,
    ST_SLOT,
    ST_META_RD,
    ST_META,
    ST_APPEND,
    ST_PRUNE,
    ST_WB,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic calc_quot;
    logic calc_slot;
    logic meta_rd;
    logic meta_load;
    logic append;
    logic prune_step;
    logic meta_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rec_mode;
    logic meta_known;
    logic prune_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/puswrl_ctrl.sv
// Sequencing state machine of the rate limiter: clear pass, item intake,
// lookup, append, prune walk, write-back and result hand-off. Uses puswrl_pkg.
module puswrl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output puswrl_pkg::dp_cmd_t    cmd,
  input  puswrl_pkg::dp_status_t status
);
  import puswrl_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd.calc_quot = 1'b1;
        state_next    = ST_SLOT;
      end
      ST_SLOT: begin
        cmd.calc_slot = 1'b1;
        state_next    = ST_META_RD;
      end
      ST_META_RD: begin
        cmd.meta_rd = 1'b1;
        state_next  = ST_META;
      end
      ST_META: begin
        cmd.meta_load = 1'b1;
        if (status.rec_mode) begin
          state_next = ST_APPEND;
        end else if (status.meta_known) begin
          state_next = ST_PRUNE;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_PRUNE;
      end
      ST_PRUNE: begin
        cmd.prune_step = 1'b1;
        if (status.prune_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        cmd.meta_wr = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/puswrl_dp.sv
// Datapath of the rate limiter: user reduction, per-slot ring metadata and
// stamp memories, prune walk and output register. Uses puswrl_pkg.
module puswrl_dp #(
  parameter int USERS     = 64,
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  puswrl_pkg::dp_cmd_t                  cmd,
  output puswrl_pkg::dp_status_t               status,
  input  logic                                 mode,
  input  logic                                 kind,
  input  logic [puswrl_pkg::USER_W-1:0]        user_index,
  input  logic [TIME_BITS-1:0]                 now_ticks,
  input  logic [puswrl_pkg::LIMIT_W-1:0]       message_limit,
  input  logic [puswrl_pkg::LIMIT_W-1:0]       command_limit,
  input  logic [puswrl_pkg::WINDOW_W-1:0]      window_ticks,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(DEPTH+1)-1:0]           event_count,
  output logic                                 over_limit,
  output logic                                 user_known
);
  import puswrl_pkg::*;

  localparam int SLOTS = 2 * USERS;
  localparam int SW    = $clog2(SLOTS);
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUMW  = CW + 1;
  localparam int RECIP = (2 ** QUOT_SHIFT + USERS - 1) / USERS;
  localparam int PRODW = USER_W + QUOT_SHIFT + 1;
  localparam int AGEW  = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
  localparam int CMPW  = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef struct packed {
    logic          known;
    logic [PW-1:0] ptr;
    logic [CW-1:0] cnt;
  } meta_t;

  // Item registers
  logic                 item_mode;
  logic                 item_kind;
  logic [USER_W-1:0]    item_user;
  logic [TIME_BITS-1:0] item_now;
  logic [USER_W-1:0]    quot;
  logic [SW-1:0]        slot;

  // Memories
  meta_t                meta_mem [SLOTS];
  meta_t                meta_rdata;
  logic [TIME_BITS-1:0] stamp_mem [SLOTS][DEPTH];
  logic [TIME_BITS-1:0] stamp_rdata;
  logic [SW-1:0]        clr_addr;

  // Working copy of the slot's ring state
  logic          wk_known;
  logic [PW-1:0] wk_ptr;
  logic [CW-1:0] wk_cnt;
  logic [CW-1:0] rd_i;
  logic [CW-1:0] kept;
  logic          pending;

  // Combinational helpers
  logic [PRODW-1:0]     prod;
  logic [USER_W-1:0]    rem;
  logic                 full;
  logic [PW-1:0]        app_pos;
  logic [PW-1:0]        ptr_inc;
  logic [PW-1:0]        rd_pos;
  logic [PW-1:0]        keep_pos;
  logic                 issue;
  logic [TIME_BITS-1:0] age;
  logic                 keep;
  logic                 stamp_we;
  logic [PW-1:0]        stamp_wpos;
  logic [TIME_BITS-1:0] stamp_wdata;
  logic [LIMIT_W-1:0]   limit;

  // Fold a sum below twice the ring depth back into the ring
  function automatic logic [PW-1:0] ring_pos(input logic [SUMW-1:0] s);
    logic [SUMW-1:0] d;
    d = s - SUMW'(DEPTH);
    if (s >= SUMW'(DEPTH)) begin
      return d[PW-1:0];
    end
    return s[PW-1:0];
  endfunction

  // User modulo USERS by reciprocal multiply, then back-multiply
  assign prod = PRODW'(item_user) * PRODW'(RECIP);
  assign rem  = item_user - USER_W'(quot * USERS);

  // Ring positions
  assign full     = (wk_cnt == CW'(DEPTH));
  assign ptr_inc  = ring_pos(SUMW'(wk_ptr) + SUMW'(1));
  assign app_pos  = full ? wk_ptr : ring_pos(SUMW'(wk_ptr) + SUMW'(wk_cnt));
  assign rd_pos   = ring_pos(SUMW'(wk_ptr) + SUMW'(rd_i));
  assign keep_pos = ring_pos(SUMW'(wk_ptr) + SUMW'(kept));
  assign issue    = cmd.prune_step && (rd_i < wk_cnt);

  // Window test on the stamp read last cycle
  assign age  = item_now - stamp_rdata;
  assign keep = (AGEW'(age) <= AGEW'(window_ticks));

  // Stamp write port: append or compact a survivor
  assign stamp_we    = cmd.append || (cmd.prune_step && pending && keep);
  assign stamp_wpos  = cmd.append ? app_pos : keep_pos;
  assign stamp_wdata = cmd.append ? item_now : stamp_rdata;

  assign limit = item_kind ? command_limit : message_limit;

  // Status to controller
  always_comb begin
    status.clr_last   = (clr_addr == SW'(SLOTS - 1));
    status.rec_mode   = item_mode;
    status.meta_known = meta_rdata.known;
    status.prune_done = (rd_i == wk_cnt) && !pending;
    status.out_free   = !out_valid || !out_stall;
  end

  // Capture item, reduce user to slot
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_mode <= mode;
      item_kind <= kind;
      item_user <= user_index;
      item_now  <= now_ticks;
    end
    if (cmd.calc_quot) begin
      quot <= prod[USER_W+QUOT_SHIFT-1:QUOT_SHIFT];
    end
    if (cmd.calc_slot) begin
      slot <= SW'(rem) + (item_kind ? SW'(USERS) : SW'(0));
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + SW'(1);
    end
  end

  // Metadata memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      meta_mem[clr_addr] <= '0;
    end else if (cmd.meta_wr) begin
      meta_mem[slot] <= '{known: wk_known, ptr: wk_ptr, cnt: kept};
    end
    if (cmd.meta_rd) begin
      meta_rdata <= meta_mem[slot];
    end
  end

  // Stamp memory
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[slot][stamp_wpos] <= stamp_wdata;
    end
    if (issue) begin
      stamp_rdata <= stamp_mem[slot][rd_pos];
    end
  end

  // Working ring state and prune walk
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (cmd.meta_load) begin
      pending <= 1'b0;
    end else if (cmd.prune_step) begin
      pending <= issue;
    end
    if (cmd.meta_load) begin
      wk_known <= meta_rdata.known;
      wk_ptr   <= meta_rdata.ptr;
      wk_cnt   <= meta_rdata.cnt;
      rd_i     <= '0;
      kept     <= '0;
    end else if (cmd.append) begin
      wk_known <= 1'b1;
      if (full) begin
        wk_ptr <= ptr_inc;
      end else begin
        wk_cnt <= wk_cnt + CW'(1);
      end
    end else if (cmd.prune_step) begin
      if (issue) begin
        rd_i <= rd_i + CW'(1);
      end
      if (pending && keep) begin
        kept <= kept + CW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      event_count <= kept;
      over_limit  <= (CMPW'(kept) > CMPW'(limit));
      user_known  <= wk_known;
    end
  end

endmodule

>>> rtl/per_user_sliding_window_rate_limiter.sv
// Per-user sliding-window rate limiter: top level with configuration registers.
// Depends on puswrl_pkg, puswrl_ctrl, puswrl_dp and the assertion macro header.
//
// Usage: each input item (mode, kind, user_index, now_ticks) is taken on
// in_valid with in_stall low and yields exactly one result item
// (event_count, over_limit, user_known) on out_valid, held until out_stall
// is low. Configuration (message_limit, command_limit, window_ticks) is
// written through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, and writes belong in idle periods.
// Timing: one item at a time. After acceptance the controller steps through
// QUOT, SLOT, META_RD, META, APPEND (records only), PRUNE (records and known
// users), WB and DONE; the prune walk takes longer the more stamps the
// addressed ring holds. A new item is taken only back in IDLE, once the
// result has been loaded. The prune walk reads the ring one stamp per cycle
// through the single stamp memory read port.
// Reset: configuration returns to its defaults and a clearing pass zeroes
// the ring metadata of all 2*USERS slots, with in_stall high.
// A stalled result stays in the output register; the block still accepts and
// works on the next item, then waits before overwriting the pending result.
`include "per_user_sliding_window_rate_limiter_macros.svh"

module per_user_sliding_window_rate_limiter #(
  parameter int USERS     = 64,
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic                                kind,
  input  logic [puswrl_pkg::USER_W-1:0]       user_index,
  input  logic [TIME_BITS-1:0]                now_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(DEPTH+1)-1:0]          event_count,
  output logic                                over_limit,
  output logic                                user_known,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [puswrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [puswrl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import puswrl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [LIMIT_W-1:0]  message_limit;
  logic [LIMIT_W-1:0]  command_limit;
  logic [WINDOW_W-1:0] window_ticks;
  dp_cmd_t             cmd;
  dp_status_t          status;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      message_limit <= MESSAGE_LIMIT_RST;
      command_limit <= COMMAND_LIMIT_RST;
      window_ticks  <= WINDOW_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MESSAGE_LIMIT: message_limit <= cfg_data[LIMIT_W-1:0];
        CFG_COMMAND_LIMIT: command_limit <= cfg_data[LIMIT_W-1:0];
        CFG_WINDOW_TICKS:  window_ticks  <= cfg_data[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  puswrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  puswrl_dp #(
    .USERS     (USERS),
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .kind          (kind),
    .user_index    (user_index),
    .now_ticks     (now_ticks),
    .message_limit (message_limit),
    .command_limit (command_limit),
    .window_ticks  (window_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_count   (event_count),
    .over_limit    (over_limit),
    .user_known    (user_known)
  );

  // Checks
  `PUSWRL_ASSERT_NOW(a_count_bound, out_valid, event_count <= CW'(DEPTH))
  `PUSWRL_ASSERT_NOW(a_over_needs_known, out_valid && over_limit, user_known)
  `PUSWRL_ASSERT_NOW(a_unknown_empty, out_valid && !user_known, event_count == '0)
  `PUSWRL_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `PUSWRL_ASSERT_NOW(a_clear_after_reset, $past(rst), in_stall)

endmodule

>>> test/window_count_checker.sv
// Checker for the per-user sliding-window rate limiter: mirrors the config writes,
// keeps its own copy of every user's stamp ring, and compares each result item.
// Depends on puswrl_pkg for register indexes and reset values.
module window_count_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              mode,
  input  logic                              kind,
  input  logic [puswrl_pkg::USER_W-1:0]     user_index,
  input  logic [31:0]                       now_ticks,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [4:0]                        event_count,
  input  logic                              over_limit,
  input  logic                              user_known,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [puswrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [puswrl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                mismatches,
  output int                                outstanding,
  output int                                compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import puswrl_pkg::*;

  localparam int USER_SLOTS = 64;
  localparam int RING_DEPTH = 16;
  localparam int SLOT_COUNT = 2 * USER_SLOTS;

  typedef struct packed {
    logic [4:0] count;
    logic       over;
    logic       known;
  } window_result_t;

  // Predicted state: one stamp ring per (kind, user) slot
  logic [31:0]         ring_stamp [SLOT_COUNT][RING_DEPTH];
  logic [3:0]          ring_head  [SLOT_COUNT];
  logic [4:0]          ring_live  [SLOT_COUNT];
  logic                slot_known [SLOT_COUNT];
  logic [LIMIT_W-1:0]  msg_limit;
  logic [LIMIT_W-1:0]  cmd_limit;
  logic [WINDOW_W-1:0] window_len;

  window_result_t expected_counts [$];
  int fail_total = 0;
  int seen_total = 0;

  // Apply one item to the predicted rings and return its result
  function automatic window_result_t predict_window_count(logic rec, logic knd,
                                                          logic [USER_W-1:0] usr,
                                                          logic [31:0] t);
    int             slot;
    int             live;
    int             kept;
    logic [31:0]    keep [RING_DEPTH];
    logic [31:0]    stamp;
    logic [31:0]    stamp_age;
    logic [3:0]     lim;
    window_result_t res;
    slot = int'(knd) * USER_SLOTS + int'(usr);
    lim  = knd ? cmd_limit : msg_limit;
    res  = '0;
    // a check on a user never recorded reports nothing and changes nothing
    if (!rec && !slot_known[slot]) return res;
    // append, overwriting the oldest stamp when the ring is full
    if (rec) begin
      live = int'(ring_live[slot]);
      if (live >= RING_DEPTH) begin
        ring_stamp[slot][ring_head[slot]] = t;
        ring_head[slot] = ring_head[slot] + 4'd1;
      end else begin
        ring_stamp[slot][(int'(ring_head[slot]) + live) % RING_DEPTH] = t;
        ring_live[slot] = 5'(live + 1);
      end
      slot_known[slot] = 1'b1;
    end
    // drop stale stamps and repack the survivors from the oldest position
    live = int'(ring_live[slot]);
    kept = 0;
    for (int i = 0; i < live; i++) begin
      stamp     = ring_stamp[slot][(int'(ring_head[slot]) + i) % RING_DEPTH];
      stamp_age = t - stamp;
      if (stamp_age <= 32'(window_len)) begin
        keep[kept] = stamp;
        kept++;
      end
    end
    for (int i = 0; i < kept; i++)
      ring_stamp[slot][(int'(ring_head[slot]) + i) % RING_DEPTH] = keep[i];
    ring_live[slot] = 5'(kept);
    res.count = ring_live[slot];
    res.over  = (ring_live[slot] > 5'(lim));
    res.known = 1'b1;
    return res;
  endfunction

  // Track config, compare results, queue predictions
  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      msg_limit  = MESSAGE_LIMIT_RST;
      cmd_limit  = COMMAND_LIMIT_RST;
      window_len = WINDOW_TICKS_RST;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        ring_head[s]  = '0;
        ring_live[s]  = '0;
        slot_known[s] = 1'b0;
      end
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MESSAGE_LIMIT: msg_limit  = cfg_data[LIMIT_W-1:0];
          CFG_COMMAND_LIMIT: cmd_limit  = cfg_data[LIMIT_W-1:0];
          CFG_WINDOW_TICKS:  window_len = cfg_data[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          $error("result item with no prediction pending: event_count %0d", event_count);
          fail_total++;
        end else begin
          want = expected_counts.pop_front();
          seen_total++;
          if (event_count !== want.count) begin
            $error("event_count mismatch: expected %0d, actual %0d", want.count, event_count);
            fail_total++;
          end
          if (over_limit !== want.over) begin
            $error("over_limit mismatch: expected %0d, actual %0d", want.over, over_limit);
            fail_total++;
          end
          if (user_known !== want.known) begin
            $error("user_known mismatch: expected %0d, actual %0d", want.known, user_known);
            fail_total++;
          end
        end
      end
      // queue the prediction behind every earlier one
      if (in_valid && !in_stall)
        expected_counts.insert(expected_counts.size(),
                               predict_window_count(mode, kind, user_index, now_ticks));
    end
    mismatches  <= fail_total;
    outstanding <= expected_counts.size();
    compared    <= seen_total;
  end

endmodule

>>> test/per_user_sliding_window_rate_limiter_tb.sv
// Top of the rate limiter testbench: clock, reset, directed and random items,
// random back-pressure, config phases and the verdict.
// Depends on puswrl_pkg, the rate limiter RTL and window_count_checker.
module per_user_sliding_window_rate_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import puswrl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 320;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  mode;
  logic                  kind;
  logic [USER_W-1:0]     user_index;
  logic [31:0]           now_ticks;
  logic                  out_valid;
  logic                  out_stall;
  logic [4:0]            event_count;
  logic                  over_limit;
  logic                  user_known;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    compared;

  int idle_pct  = 20;
  int stall_pct = 20;
  int items_sent = 0;
  int settings_used = 1;

  per_user_sliding_window_rate_limiter uut (.*);
  window_count_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random back-pressure on the result side
  always @(posedge clk)
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < stall_pct);

  // Offer one item, idling at random first, and hold it until taken
  task automatic send_event(logic rec, logic knd, logic [USER_W-1:0] usr, logic [31:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= rec;
    kind       <= knd;
    user_index <= usr;
    now_ticks  <= t;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0]       clock_now;
    logic [31:0]       t;
    logic [19:0]       win;
    logic [3:0]        mlim;
    logic [3:0]        clim;
    logic [15:0]       pad;
    logic [USER_W-1:0] focus [3];
    logic [USER_W-1:0] usr;
    logic              rec;
    logic              knd;
    int                step_max;
    int                roll;

    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = 1'b0;
    kind       = 1'b0;
    user_index = '0;
    now_ticks  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_MESSAGE_LIMIT;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: unknown user, time wrap, saturation, full expiry, future stamp
    send_event(1'b0, 1'b0, 6'd0, 32'd0);
    send_event(1'b1, 1'b1, 6'd63, 32'hFFFF_FFF0);
    send_event(1'b1, 1'b1, 6'd63, 32'h0000_0005);
    for (int i = 0; i < 17; i++)
      send_event(1'b1, 1'b0, 6'd1, 32'd1000 + 32'(i));
    send_event(1'b0, 1'b0, 6'd1, 32'd1016 + 32'd10001);
    send_event(1'b0, 1'b1, 6'd63, 32'h0000_0004);

    // Directed: zero window keeps only stamps equal to the current time
    drain_results();
    write_reg(CFG_WINDOW_TICKS, 20'd0);
    settings_used++;
    send_event(1'b1, 1'b1, 6'd2, 32'd77);
    send_event(1'b1, 1'b1, 6'd2, 32'd77);
    send_event(1'b1, 1'b1, 6'd2, 32'd78);
    send_event(1'b0, 1'b1, 6'd2, 32'd78);

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      mlim      = 4'($urandom_range(0, 15));
      clim      = 4'($urandom_range(0, 15));
      pad       = '0;
      clock_now = $urandom();
      idle_pct  = 20;
      stall_pct = 20;
      case (ph)
        0: begin
          mlim = 4'd0;
          clim = 4'd15;
          win  = 20'd64;
        end
        1: begin
          win = 20'd1;
          write_reg(CFG_UNUSED, 20'($urandom()));
        end
        2: begin
          mlim      = 4'd15;
          clim      = 4'd0;
          win       = 20'd1000000;
          clock_now = 32'hFFF0_0000;
        end
        3: begin
          win       = 20'($urandom_range(1, 5000));
          idle_pct  = 0;
          stall_pct = 0;
        end
        4: begin
          win = 20'hFFFFF;
          pad = 16'($urandom());
        end
        default: begin
          win = 20'($urandom_range(1, 1000000));
          pad = 16'($urandom());
        end
      endcase
      write_reg(CFG_MESSAGE_LIMIT, {pad, mlim});
      write_reg(CFG_COMMAND_LIMIT, {~pad, clim});
      write_reg(CFG_WINDOW_TICKS, win);
      settings_used++;
      step_max = int'(win) / 6 + 1;
      for (int k = 0; k < 3; k++) focus[k] = 6'($urandom());

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        knd  = 1'($urandom());
        if (roll < 82) begin
          // well-formed traffic on a few busy users, time mostly advancing
          usr = focus[$urandom_range(0, 2)];
          rec = ($urandom_range(0, 99) < 80);
          if ($urandom_range(0, 99) < 3) begin
            t = clock_now - 32'($urandom_range(0, int'(win)));
          end else begin
            clock_now = clock_now + 32'($urandom_range(0, step_max));
            t = clock_now;
          end
        end else begin
          // noise: any user, any mode, any time
          usr = 6'($urandom());
          rec = 1'($urandom());
          t   = $urandom();
        end
        send_event(rec, knd, usr, t);
      end
    end

    // Wait for the last results, then report
    drain_results();
    repeat (30) @(posedge clk);
    $display("Summary: %0d items under %0d configurations, %0d results compared",
             items_sent, settings_used, compared);
    $display("Covered: unknown users, saturated rings, expiry, zero and maximum windows");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
